// ----- rtl/core/vtp_pkg.sv -----
// Shared types and constants for the vignette test-pattern pixel pipeline.
// Used by every module under rtl/core; depends on nothing else.
package vtp_pkg;

  localparam int REG_BITS     = 13;  // frame size registers
  localparam int HALF_BITS    = 12;  // halved frame size
  localparam int SQ_HALF_BITS = 24;  // square of a halved frame size
  localparam int DEN_BITS     = 48;  // hw^2 * hh^2
  localparam int REM_BITS     = 56;  // positive vignette numerator, at most 255 * den
  localparam int QUOT_BITS    = 6;   // darkening quotient, below 64
  localparam int CHAN_BITS    = 8;
  localparam int GLOW_BITS    = 9;
  localparam int DIST_BITS    = 5;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [DIST_BITS-1:0] DIST_CAP    = 5'd31;
  localparam logic [GLOW_BITS-1:0] GLOW_SEED   = 9'h1FF;
  localparam logic [QUOT_BITS-1:0] DARK_MAX    = 6'd50;
  localparam logic [REG_BITS-1:0]  FRAME_RESET = 13'd256;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Per-pixel values that ride along with the vignette arithmetic
  typedef struct packed {
    logic [GLOW_BITS-1:0] glow;
    logic [CHAN_BITS-1:0] base_r;
    logic [CHAN_BITS-1:0] base_g;
    logic [CHAN_BITS-1:0] base_b;
  } pix_side_t;

endpackage

// ----- rtl/core/vtp_front.sv -----
// First pipeline stage: border glow, base colors, halved frame size and
// distances from the frame center. Depends on vtp_pkg.
module vtp_front #(
  parameter int COORD_BITS = 12,
  parameter int DIFF_BITS  = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [COORD_BITS-1:0]               pixel_x,
  input  logic [COORD_BITS-1:0]               pixel_y,
  input  logic [vtp_pkg::REG_BITS-1:0]        frame_width,
  input  logic [vtp_pkg::REG_BITS-1:0]        frame_height,
  output logic                                valid_o,
  output logic [vtp_pkg::HALF_BITS-1:0]       hw_o,
  output logic [vtp_pkg::HALF_BITS-1:0]       hh_o,
  output logic [DIFF_BITS-1:0]                dx_o,
  output logic [DIFF_BITS-1:0]                dy_o,
  output vtp_pkg::pix_side_t                  side_o
);

  localparam int CMP_BITS  = (COORD_BITS > vtp_pkg::REG_BITS) ? COORD_BITS
                                                               : vtp_pkg::REG_BITS;
  localparam int BASE_BITS = (COORD_BITS > vtp_pkg::CHAN_BITS) ? COORD_BITS
                                                                : vtp_pkg::CHAN_BITS;

  function automatic logic [vtp_pkg::DIST_BITS-1:0] cap_dist(input logic [CMP_BITS-1:0] d);
    logic [vtp_pkg::DIST_BITS-1:0] res;
    if (d > CMP_BITS'(vtp_pkg::DIST_CAP)) res = vtp_pkg::DIST_CAP;
    else res = d[vtp_pkg::DIST_BITS-1:0];
    return res;
  endfunction

  function automatic logic [vtp_pkg::DIST_BITS-1:0] min_dist(
    input logic [vtp_pkg::DIST_BITS-1:0] a,
    input logic [vtp_pkg::DIST_BITS-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  logic [CMP_BITS-1:0]                 x_c, y_c, fw_c, fh_c, far_x, far_y;
  logic [vtp_pkg::DIST_BITS-1:0]       near_dist;
  logic [vtp_pkg::HALF_BITS-1:0]       hw_nxt, hh_nxt;
  logic signed [DIFF_BITS:0]           xs, ys, xn, yn;
  logic [DIFF_BITS-1:0]                dx_nxt, dy_nxt;
  logic [BASE_BITS-1:0]                xb_full, yb_full;
  logic [vtp_pkg::CHAN_BITS-1:0]       xb, yb;
  vtp_pkg::pix_side_t                  side_nxt;

  logic                                valid_r;
  logic [vtp_pkg::HALF_BITS-1:0]       hw_r, hh_r;
  logic [DIFF_BITS-1:0]                dx_r, dy_r;
  vtp_pkg::pix_side_t                  side_r;

  always_comb begin
    // nearest edge distance, capped; a far edge behind the pixel is left out
    x_c   = CMP_BITS'(pixel_x);
    y_c   = CMP_BITS'(pixel_y);
    fw_c  = CMP_BITS'(frame_width);
    fh_c  = CMP_BITS'(frame_height);
    far_x = fw_c - x_c - CMP_BITS'(1);
    far_y = fh_c - y_c - CMP_BITS'(1);
    near_dist = min_dist(cap_dist(x_c), cap_dist(y_c));
    if (x_c < fw_c) near_dist = min_dist(near_dist, cap_dist(far_x));
    if (y_c < fh_c) near_dist = min_dist(near_dist, cap_dist(far_y));
    side_nxt.glow = vtp_pkg::GLOW_SEED >> near_dist;

    xb_full = BASE_BITS'(pixel_x);
    yb_full = BASE_BITS'(pixel_y);
    xb = xb_full[vtp_pkg::CHAN_BITS-1:0];
    yb = yb_full[vtp_pkg::CHAN_BITS-1:0];
    side_nxt.base_r = ~xb & ~yb;
    side_nxt.base_g = xb & ~yb;
    side_nxt.base_b = ~xb & yb;

    // a halved size of zero counts as one
    hw_nxt = frame_width[vtp_pkg::REG_BITS-1:1];
    hh_nxt = frame_height[vtp_pkg::REG_BITS-1:1];
    if (hw_nxt == '0) hw_nxt = vtp_pkg::HALF_BITS'(1);
    if (hh_nxt == '0) hh_nxt = vtp_pkg::HALF_BITS'(1);

    xs = $signed({1'b0, DIFF_BITS'(pixel_x)}) - $signed({1'b0, DIFF_BITS'(hw_nxt)});
    ys = $signed({1'b0, DIFF_BITS'(pixel_y)}) - $signed({1'b0, DIFF_BITS'(hh_nxt)});
    xn = -xs;
    yn = -ys;
    dx_nxt = xs[DIFF_BITS] ? xn[DIFF_BITS-1:0] : xs[DIFF_BITS-1:0];
    dy_nxt = ys[DIFF_BITS] ? yn[DIFF_BITS-1:0] : ys[DIFF_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hw_r   <= hw_nxt;
      hh_r   <= hh_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      side_r <= side_nxt;
    end
  end

  assign valid_o = valid_r;
  assign hw_o    = hw_r;
  assign hh_o    = hh_r;
  assign dx_o    = dx_r;
  assign dy_o    = dy_r;
  assign side_o  = side_r;

endmodule

// ----- rtl/core/vtp_mult.sv -----
// Vignette numerator in four stages: squares, cross products, sum, and
// V = 255*D - 800*S with D = hw^2*hh^2. Depends on vtp_pkg.
module vtp_mult #(
  parameter int DIFF_BITS = 12,
  parameter int PROD_BITS = 48,
  parameter int VIG_BITS  = 60
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             valid_i,
  input  logic [vtp_pkg::HALF_BITS-1:0]    hw_i,
  input  logic [vtp_pkg::HALF_BITS-1:0]    hh_i,
  input  logic [DIFF_BITS-1:0]             dx_i,
  input  logic [DIFF_BITS-1:0]             dy_i,
  input  vtp_pkg::pix_side_t               side_i,
  output logic                             valid_o,
  output logic signed [VIG_BITS-1:0]       v_o,
  output logic [vtp_pkg::DEN_BITS-1:0]     den_o,
  output vtp_pkg::pix_side_t               side_o
);

  localparam int SQ_BITS  = 2 * DIFF_BITS;
  localparam int SUM_BITS = PROD_BITS + 1;

  // stage b: squares
  logic                                 valid_b_r;
  logic [vtp_pkg::SQ_HALF_BITS-1:0]     hw2_b_r, hh2_b_r;
  logic [SQ_BITS-1:0]                   dx2_b_r, dy2_b_r;
  vtp_pkg::pix_side_t                   side_b_r;
  // stage c: products
  logic                                 valid_c_r;
  logic [vtp_pkg::DEN_BITS-1:0]         den_c_r;
  logic [PROD_BITS-1:0]                 p1_c_r, p2_c_r;
  vtp_pkg::pix_side_t                   side_c_r;
  // stage d: sum
  logic                                 valid_d_r;
  logic [vtp_pkg::DEN_BITS-1:0]         den_d_r;
  logic [SUM_BITS-1:0]                  s_d_r;
  vtp_pkg::pix_side_t                   side_d_r;
  // stage e: numerator
  logic                                 valid_e_r;
  logic [vtp_pkg::DEN_BITS-1:0]         den_e_r;
  logic signed [VIG_BITS-1:0]           v_e_r;
  vtp_pkg::pix_side_t                   side_e_r;

  logic [vtp_pkg::SQ_HALF_BITS-1:0]     hw2_nxt, hh2_nxt;
  logic [SQ_BITS-1:0]                   dx2_nxt, dy2_nxt;
  logic [vtp_pkg::DEN_BITS-1:0]         den_nxt;
  logic [PROD_BITS-1:0]                 p1_nxt, p2_nxt;
  logic [SUM_BITS-1:0]                  s_nxt;
  logic [VIG_BITS-1:0]                  se, de, v_nxt;

  always_comb begin
    hw2_nxt = vtp_pkg::SQ_HALF_BITS'(hw_i) * vtp_pkg::SQ_HALF_BITS'(hw_i);
    hh2_nxt = vtp_pkg::SQ_HALF_BITS'(hh_i) * vtp_pkg::SQ_HALF_BITS'(hh_i);
    dx2_nxt = SQ_BITS'(dx_i) * SQ_BITS'(dx_i);
    dy2_nxt = SQ_BITS'(dy_i) * SQ_BITS'(dy_i);

    den_nxt = vtp_pkg::DEN_BITS'(hw2_b_r) * vtp_pkg::DEN_BITS'(hh2_b_r);
    p1_nxt  = PROD_BITS'(dx2_b_r) * PROD_BITS'(hh2_b_r);
    p2_nxt  = PROD_BITS'(dy2_b_r) * PROD_BITS'(hw2_b_r);

    s_nxt = SUM_BITS'(p1_c_r) + SUM_BITS'(p2_c_r);

    // 255 = 256 - 1, 800 = 512 + 256 + 32
    se    = VIG_BITS'(s_d_r);
    de    = VIG_BITS'(den_d_r);
    v_nxt = (de << 8) - de - ((se << 9) + (se << 8) + (se << 5));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
      valid_d_r <= 1'b0;
      valid_e_r <= 1'b0;
    end else if (en) begin
      valid_b_r <= valid_i;
      valid_c_r <= valid_b_r;
      valid_d_r <= valid_c_r;
      valid_e_r <= valid_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hw2_b_r  <= hw2_nxt;
      hh2_b_r  <= hh2_nxt;
      dx2_b_r  <= dx2_nxt;
      dy2_b_r  <= dy2_nxt;
      side_b_r <= side_i;

      den_c_r  <= den_nxt;
      p1_c_r   <= p1_nxt;
      p2_c_r   <= p2_nxt;
      side_c_r <= side_b_r;

      den_d_r  <= den_c_r;
      s_d_r    <= s_nxt;
      side_d_r <= side_c_r;

      den_e_r  <= den_d_r;
      v_e_r    <= $signed(v_nxt);
      side_e_r <= side_d_r;
    end
  end

  assign valid_o = valid_e_r;
  assign v_o     = v_e_r;
  assign den_o   = den_e_r;
  assign side_o  = side_e_r;

endmodule

// ----- rtl/core/vtp_div.sv -----
// Darkening quotient floor(V / D) clamped to 0..50: a clamp stage, then one
// restoring compare-subtract stage per quotient bit. Depends on vtp_pkg.
module vtp_div #(
  parameter int VIG_BITS = 60
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             valid_i,
  input  logic signed [VIG_BITS-1:0]       v_i,
  input  logic [vtp_pkg::DEN_BITS-1:0]     den_i,
  input  vtp_pkg::pix_side_t               side_i,
  output logic                             valid_o,
  output logic [vtp_pkg::QUOT_BITS-1:0]    dark_o,
  output vtp_pkg::pix_side_t               side_o
);

  localparam int Q = vtp_pkg::QUOT_BITS;

  logic                                valid_r [0:Q];
  logic                                zero_r  [0:Q];
  logic                                sat_r   [0:Q];
  logic [vtp_pkg::REM_BITS-1:0]        rem_r   [0:Q];
  logic [vtp_pkg::DEN_BITS-1:0]        den_r   [0:Q];
  logic [Q-1:0]                        quot_r  [0:Q];
  vtp_pkg::pix_side_t                  side_r  [0:Q];

  logic [VIG_BITS-1:0]                 den_ext, den50;
  logic                                zero_nxt, sat_nxt;

  always_comb begin
    den_ext  = VIG_BITS'(den_i);
    den50    = (den_ext << 5) + (den_ext << 4) + (den_ext << 1);
    zero_nxt = v_i[VIG_BITS-1] || (v_i == '0);
    sat_nxt  = !zero_nxt && (v_i >= $signed(den50));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (en) begin
      valid_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= zero_nxt;
      sat_r[0]  <= sat_nxt;
      rem_r[0]  <= v_i[vtp_pkg::REM_BITS-1:0];
      den_r[0]  <= den_i;
      quot_r[0] <= '0;
      side_r[0] <= side_i;
    end
  end

  // below the clamp V < 64*D, so six steps give the exact floor
  for (genvar k = 0; k < Q; k++) begin : g_step
    localparam int B = Q - 1 - k;

    logic [vtp_pkg::REM_BITS-1:0] trial;
    logic                         take;
    logic [vtp_pkg::REM_BITS-1:0] rem_nxt;
    logic [Q-1:0]                 quot_nxt;

    always_comb begin
      trial       = vtp_pkg::REM_BITS'(den_r[k]) << B;
      take        = rem_r[k] >= trial;
      rem_nxt     = take ? (rem_r[k] - trial) : rem_r[k];
      quot_nxt    = quot_r[k];
      quot_nxt[B] = take;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k+1] <= zero_r[k];
        sat_r[k+1]  <= sat_r[k];
        rem_r[k+1]  <= rem_nxt;
        den_r[k+1]  <= den_r[k];
        quot_r[k+1] <= quot_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  always_comb begin
    if (zero_r[Q]) dark_o = '0;
    else if (sat_r[Q]) dark_o = vtp_pkg::DARK_MAX;
    else dark_o = quot_r[Q];
  end

  assign valid_o = valid_r[Q];
  assign side_o  = side_r[Q];

  // rem_r and den_r past the last step are only kept for uniform staging
  logic unused_tail;
  assign unused_tail = ^{rem_r[Q], den_r[Q]};

  a_quot_below_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[Q] && !zero_r[Q] && !sat_r[Q] |-> quot_r[Q] < vtp_pkg::DARK_MAX)
    else $error("quotient reached the clamp without the saturate flag");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] |-> !(zero_r[0] && sat_r[0]))
    else $error("vignette numerator flagged both nonpositive and saturated");

  a_dark_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_o |-> dark_o <= vtp_pkg::DARK_MAX)
    else $error("darkening above its clamp");

endmodule

// ----- rtl/core/vignette_test_pattern_pixel.sv -----
// Top level of the vignette test-pattern pixel generator: frame size
// registers, pipeline stages and the output register with skid buffer.
// Depends on vtp_pkg, vtp_front, vtp_mult and vtp_div.
// Throughput one pixel per cycle while the skid register is empty; a pixel
// passes the front stage, four multiply stages, a clamp stage and
// six divide steps, then the output register.
// Output backpressure fills a one-entry skid register; while it is full the
// pipeline holds and in_stall is high. Synchronous active-low reset clears
// all valid bits and sets both frame size registers to 256.
module vignette_test_pattern_pixel #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [vtp_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [vtp_pkg::REG_BITS-1:0]           cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [COORD_BITS-1:0]                  in_pixel_x,
  input  logic [COORD_BITS-1:0]                  in_pixel_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [vtp_pkg::CHAN_BITS-1:0]          out_red,
  output logic [vtp_pkg::CHAN_BITS-1:0]          out_green,
  output logic [vtp_pkg::CHAN_BITS-1:0]          out_blue
);

  localparam int DIFF_BITS = (COORD_BITS > vtp_pkg::HALF_BITS) ? COORD_BITS
                                                                : vtp_pkg::HALF_BITS;
  localparam int PROD_BITS = 2 * DIFF_BITS + vtp_pkg::SQ_HALF_BITS;
  localparam int VIG_BITS  = PROD_BITS + 12;
  localparam int CW        = vtp_pkg::CHAN_BITS;
  localparam int SW        = CW + 3;

  function automatic logic [CW-1:0] shade(
    input logic [CW-1:0]                     base,
    input logic [vtp_pkg::QUOT_BITS-1:0]     dark,
    input logic [vtp_pkg::GLOW_BITS-1:0]     glow
  );
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] g;
    v = $signed(SW'(base)) - $signed(SW'(dark));
    g = $signed(SW'(glow));
    if (v < g) v = g;
    if (v > $signed(SW'(255))) v = $signed(SW'(255));
    return v[CW-1:0];
  endfunction

  logic [vtp_pkg::REG_BITS-1:0]    frame_width_r, frame_height_r;
  logic                            en;

  logic                            f_valid;
  logic [vtp_pkg::HALF_BITS-1:0]   f_hw, f_hh;
  logic [DIFF_BITS-1:0]            f_dx, f_dy;
  vtp_pkg::pix_side_t              f_side;

  logic                            m_valid;
  logic signed [VIG_BITS-1:0]      m_v;
  logic [vtp_pkg::DEN_BITS-1:0]    m_den;
  vtp_pkg::pix_side_t              m_side;

  logic                            d_valid;
  logic [vtp_pkg::QUOT_BITS-1:0]   d_dark;
  vtp_pkg::pix_side_t              d_side;

  logic                            push, out_load;
  logic [CW-1:0]                   red_new, green_new, blue_new;

  logic                            out_valid_r, out_valid_nxt;
  logic                            skid_full_r, skid_full_nxt;
  logic [CW-1:0]                   out_red_r, out_green_r, out_blue_r;
  logic [CW-1:0]                   out_red_nxt, out_green_nxt, out_blue_nxt;
  logic [CW-1:0]                   skid_red_r, skid_green_r, skid_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= vtp_pkg::FRAME_RESET;
      frame_height_r <= vtp_pkg::FRAME_RESET;
    end else if (cfg_we) begin
      case (vtp_pkg::cfg_reg_t'(cfg_index))
        vtp_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        vtp_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold the whole pipeline while the skid entry is occupied
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  vtp_front #(
    .COORD_BITS (COORD_BITS),
    .DIFF_BITS  (DIFF_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .valid_o      (f_valid),
    .hw_o         (f_hw),
    .hh_o         (f_hh),
    .dx_o         (f_dx),
    .dy_o         (f_dy),
    .side_o       (f_side)
  );

  vtp_mult #(
    .DIFF_BITS (DIFF_BITS),
    .PROD_BITS (PROD_BITS),
    .VIG_BITS  (VIG_BITS)
  ) u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (f_valid),
    .hw_i    (f_hw),
    .hh_i    (f_hh),
    .dx_i    (f_dx),
    .dy_i    (f_dy),
    .side_i  (f_side),
    .valid_o (m_valid),
    .v_o     (m_v),
    .den_o   (m_den),
    .side_o  (m_side)
  );

  vtp_div #(
    .VIG_BITS (VIG_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (m_valid),
    .v_i     (m_v),
    .den_i   (m_den),
    .side_i  (m_side),
    .valid_o (d_valid),
    .dark_o  (d_dark),
    .side_o  (d_side)
  );

  always_comb begin
    red_new   = shade(d_side.base_r, d_dark, d_side.glow);
    green_new = shade(d_side.base_g, d_dark, d_side.glow);
    blue_new  = shade(d_side.base_b, d_dark, d_side.glow);

    push     = en && d_valid;
    out_load = !out_valid_r || !out_stall;

    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    if (out_load) begin
      // refill from the skid entry first, else take the new pixel
      out_valid_nxt = skid_full_r || push;
      skid_full_nxt = 1'b0;
      out_red_nxt   = skid_full_r ? skid_red_r   : red_new;
      out_green_nxt = skid_full_r ? skid_green_r : green_new;
      out_blue_nxt  = skid_full_r ? skid_blue_r  : blue_new;
    end else if (push) begin
      skid_full_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    if (!out_load && push) begin
      skid_red_r   <= red_new;
      skid_green_r <= green_new;
      skid_blue_r  <= blue_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid entry occupied with an empty output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && out_stall && d_valid))
    else $error("skid entry filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_full_r) |-> $past(!out_stall))
    else $error("skid entry drained without an output transfer");

endmodule

// ----- verif/testbench.sv -----
// Testbench for vignette_test_pattern_pixel: random and directed pixels under several
// frame sizes, with sender gaps and receiver stalls. Each color is checked against a
// local integer model. Depends on vtp_pkg and the RTL top level only.
module testbench;

  localparam int COORD_BITS  = 12;
  localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
  localparam int WATCHDOG    = 5000;
  localparam int DRAIN_SLACK = 24;
  localparam int ITEMS_PER_FRAME = 160;

  class pixel_scoreboard;
    typedef struct {
      logic [vtp_pkg::CHAN_BITS-1:0] red;
      logic [vtp_pkg::CHAN_BITS-1:0] green;
      logic [vtp_pkg::CHAN_BITS-1:0] blue;
      int x;
      int y;
    } color_t;

    int frame_w = int'(vtp_pkg::FRAME_RESET);
    int frame_h = int'(vtp_pkg::FRAME_RESET);
    color_t expected_colors[$];
    int mismatches;
    int checked;

    function void set_frame(vtp_pkg::cfg_reg_t idx, int value);
      if (idx == vtp_pkg::CFG_FRAME_WIDTH) frame_w = value;
      else frame_h = value;
    endfunction

    function logic [vtp_pkg::CHAN_BITS-1:0] shade(int base, int dark, int glow);
      int v;
      v = base - dark;
      if (v < glow) v = glow;
      if (v > 255) v = 255;
      return v[vtp_pkg::CHAN_BITS-1:0];
    endfunction

    // Work out the color of one accepted pixel and queue it
    function void note_pixel(int x, int y);
      int near_dist;
      int glow;
      int dark;
      longint hw, hh, hw2, hh2, den, num;
      color_t c;
      near_dist = (x < y) ? x : y;
      // a far-edge distance that would go negative is left out
      if (x < frame_w && frame_w - 1 - x < near_dist) near_dist = frame_w - 1 - x;
      if (y < frame_h && frame_h - 1 - y < near_dist) near_dist = frame_h - 1 - y;
      if (near_dist > int'(vtp_pkg::DIST_CAP)) near_dist = int'(vtp_pkg::DIST_CAP);
      glow = int'(vtp_pkg::GLOW_SEED) >> near_dist;
      hw = frame_w >> 1;
      hh = frame_h >> 1;
      if (hw == 0) hw = 1;
      if (hh == 0) hh = 1;
      hw2 = hw * hw;
      hh2 = hh * hh;
      den = hw2 * hh2;
      num = 255 * den - 800 * ((longint'(x) - hw) * (longint'(x) - hw) * hh2
                               + (longint'(y) - hh) * (longint'(y) - hh) * hw2);
      if (num <= 0) dark = 0;
      else if (num >= 50 * den) dark = int'(vtp_pkg::DARK_MAX);
      else dark = int'(num / den);
      c.x = x;
      c.y = y;
      c.red   = shade(~x & ~y & 255, dark, glow);
      c.green = shade(x & ~y & 255, dark, glow);
      c.blue  = shade(~x & y & 255, dark, glow);
      expected_colors.push_back(c);
    endfunction

    function void check_pixel(logic [vtp_pkg::CHAN_BITS-1:0] r,
                              logic [vtp_pkg::CHAN_BITS-1:0] g,
                              logic [vtp_pkg::CHAN_BITS-1:0] b);
      color_t c;
      checked++;
      if (expected_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: color %h %h %h arrived with no pixel pending", r, g, b);
        return;
      end
      c = expected_colors.pop_front();
      if (r !== c.red || g !== c.green || b !== c.blue) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel (%0d,%0d) frame %0dx%0d: expected rgb %h %h %h, got %h %h %h",
                   c.x, c.y, frame_w, frame_h, c.red, c.green, c.blue, r, g, b);
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [vtp_pkg::CFG_IDX_BITS-1:0] cfg_index;
  logic [vtp_pkg::REG_BITS-1:0]     cfg_wdata;
  logic                             in_valid;
  logic                             in_stall;
  logic [COORD_BITS-1:0]            in_pixel_x;
  logic [COORD_BITS-1:0]            in_pixel_y;
  logic                             out_valid;
  logic                             out_stall;
  logic [vtp_pkg::CHAN_BITS-1:0]    out_red;
  logic [vtp_pkg::CHAN_BITS-1:0]    out_green;
  logic [vtp_pkg::CHAN_BITS-1:0]    out_blue;

  pixel_scoreboard sb;
  int send_gap_pct;
  int stall_pct;
  int pixels_sent;
  int frames_tried;
  int stuck_cycles;

  vignette_test_pattern_pixel #(.COORD_BITS(COORD_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(int'(in_pixel_x), int'(in_pixel_y));
      if (out_valid && !out_stall) sb.check_pixel(out_red, out_green, out_blue);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG) begin
      $display("watchdog: no transfer in %0d cycles", WATCHDOG);
      $display("Mismatches found");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_pixel(int x, int y);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid   = 1'b0;
      in_pixel_x = COORD_BITS'($urandom);
      in_pixel_y = COORD_BITS'($urandom);
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_pixel_x = COORD_BITS'(x);
    in_pixel_y = COORD_BITS'(y);
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every pending color has come out
  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (sb.expected_colors.size() != 0) @(negedge clk);
  endtask

  task automatic write_frame_reg(vtp_pkg::cfg_reg_t idx, int value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = vtp_pkg::REG_BITS'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_frame(idx, value);
  endtask

  function automatic int pick_coord(int size);
    int lim;
    int r;
    int c;
    lim = (size > COORD_MAX + 1) ? COORD_MAX : size - 1;
    r = $urandom_range(99);
    if (size == 0 || r < 10) return $urandom_range(COORD_MAX);
    if (r < 25) return $urandom_range(0, (lim < 40) ? lim : 40);
    if (r < 40) return lim - $urandom_range(0, (lim < 40) ? lim : 40);
    if (r < 55) begin
      c = (size >> 1) + $urandom_range(0, 40) - 20;
      if (c < 0) c = 0;
      if (c > lim) c = lim;
      return c;
    end
    return $urandom_range(0, lim);
  endfunction

  initial begin
    int dir_x[$];
    int dir_y[$];
    int widths[$];
    int heights[$];
    int phase;
    int k;
    int n;
    int f;

    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = vtp_pkg::CFG_FRAME_WIDTH;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    sb = new();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // corners, center, vignette ramp, far-edge overshoot, glow cap, bit mixes
    dir_x = '{0, 255, 0, 255, 128, 127, 128, 128, 128, 100, 1, 2, 40, 31, 32,
              4095, 300, 10, 4095, 0, 2730, 1365, 255, 254, 64};
    dir_y = '{0, 255, 255, 0, 128, 128, 100, 110, 120, 140, 1, 5, 40, 33, 200,
              4095, 10, 300, 0, 4095, 1365, 2730, 128, 253, 192};
    foreach (dir_x[i]) send_pixel(dir_x[i], dir_y[i]);

    // reset size first again, then degenerate, extreme, odd and random frames
    widths  = '{256, 2, 4096, 8191, 0, 1, 3, 4096, 640, 17, 0, 0};
    heights = '{256, 2, 4096, 8191, 1, 0, 4096, 3, 480, 9, 0, 0};
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 49; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 49; end
        default: begin send_gap_pct = 36; stall_pct = 36; end
      endcase
      for (k = 0; k < 3; k++) begin
        f = phase * 3 + k;
        if (f >= 10) begin
          widths[f]  = $urandom_range(2, 4096);
          heights[f] = $urandom_range(2, 4096);
        end
        drain_pipeline();
        write_frame_reg(vtp_pkg::CFG_FRAME_WIDTH, widths[f]);
        write_frame_reg(vtp_pkg::CFG_FRAME_HEIGHT, heights[f]);
        frames_tried++;
        for (n = 0; n < ITEMS_PER_FRAME; n++)
          send_pixel(pick_coord(widths[f]), pick_coord(heights[f]));
      end
    end

    drain_pipeline();
    repeat (DRAIN_SLACK) @(posedge clk);
    $display("Sent %0d pixels over %0d frame sizes (degenerate, 4096 and 13-bit maximum",
             pixels_sent, frames_tried);
    $display("included) with sender gaps and receiver stalls; %0d colors checked.",
             sb.checked);
    if (sb.mismatches == 0 && sb.expected_colors.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/vtp_pkg.sv
rtl/core/vtp_front.sv
rtl/core/vtp_mult.sv
rtl/core/vtp_div.sv
rtl/core/vignette_test_pattern_pixel.sv
verif/testbench.sv
